FILE: hw/rtl/least_squares_line_fit_top_macros.svh
// Assertion macros shared by the line-fit RTL
`ifndef LEAST_SQUARES_LINE_FIT_TOP_MACROS_SVH
`define LEAST_SQUARES_LINE_FIT_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define LSLF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define LSLF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/lslf_pkg.sv
// Shared constants and types of the least-squares line fit
package lslf_pkg;

  localparam int DEF_MAX_SAMPLES  = 4096;
  localparam int DEF_SAMPLE_WIDTH = 16;
  localparam int DEF_SAMPLE_FRAC  = 8;
  localparam int DEF_RESULT_FRAC  = 16;

  localparam int RES_W       = 32;
  localparam int Q_W         = RES_W + 1;
  localparam int COUNT_OUT_W = 13;
  localparam int STATUS_W    = 2;
  localparam int SUM_W       = 32;
  localparam int WIDE_W      = 48;
  localparam int HALF_W      = WIDE_W / 2;
  localparam int MUL_W       = 33;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int ACC_W       = 82;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK, ST_SINGULAR, ST_TOO_MANY, ST_SATURATED
  } fit_status_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic sat;
  } div_stat_t;

endpackage

FILE: hw/rtl/least_squares_line_fit_top.sv
// Least-squares line fit: top level with shared multiplier and divider sequencer
//
//   channel | dir | handshake            | payload
//   --------+-----+----------------------+------------------------------------------------
//   in      | in  | in_valid / in_ready  | sample_x, sample_y, last_sample
//   out     | out | out_valid / out_ready| slope, intercept, sample_count, fit_status
//
// A sample passes through the shared 33x33 multiplier in steps: transfer, x*y, x*x, sum update;
// a sample past MAX_SAMPLES is dropped in its transfer cycle. A last sample then adds a
// partial-product pass, a check, two divisions (none on a singular or overflowed run)
// and an output step.
// rst clears the sums, the count and the sequencer; there is no clearing pass.
// in_ready is low while a sample is processed; a fit waiting on out_ready holds it low too.
`include "least_squares_line_fit_top_macros.svh"

module least_squares_line_fit_top #(
  parameter int MAX_SAMPLES  = lslf_pkg::DEF_MAX_SAMPLES,
  parameter int SAMPLE_WIDTH = lslf_pkg::DEF_SAMPLE_WIDTH,
  parameter int SAMPLE_FRAC  = lslf_pkg::DEF_SAMPLE_FRAC,
  parameter int RESULT_FRAC  = lslf_pkg::DEF_RESULT_FRAC
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]         sample_x,
  input  logic signed [SAMPLE_WIDTH-1:0]         sample_y,
  input  logic                                   last_sample,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [lslf_pkg::RES_W-1:0]      slope,
  output logic signed [lslf_pkg::RES_W-1:0]      intercept,
  output logic [lslf_pkg::COUNT_OUT_W-1:0]       sample_count,
  output logic [lslf_pkg::STATUS_W-1:0]          fit_status
);
  import lslf_pkg::*;

  localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
  localparam int NUM_W   = ACC_W + RESULT_FRAC;
  localparam int DEN_W   = ACC_W + SAMPLE_FRAC;
  localparam int FIT_OPS = 10;
  localparam int OP_W    = $clog2(FIT_OPS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_MXY, S_MXX, S_ACC, S_PROD, S_CHECK, S_DIV_SLOPE, S_DIV_ICPT, S_OUT
  } state_t;

  typedef enum logic [1:0] {A_N, A_SX, A_SY} a_sel_t;
  typedef enum logic [2:0] {B_SXX_LO, B_SXX_HI, B_SXY_LO, B_SXY_HI, B_SX, B_SY} b_sel_t;
  typedef enum logic [1:0] {ACC_DEN, ACC_NUM, ACC_PNUM} acc_sel_t;

  typedef struct packed {
    a_sel_t   a;
    b_sel_t   b;
    acc_sel_t tgt;
    logic     hi;
    logic     sub;
  } fit_op_t;

  function automatic fit_op_t fit_op(input logic [OP_W-1:0] idx);
    fit_op_t op;
    case (idx)
      0:       op = '{a: A_N,  b: B_SXX_LO, tgt: ACC_DEN,  hi: 1'b0, sub: 1'b0};
      1:       op = '{a: A_N,  b: B_SXX_HI, tgt: ACC_DEN,  hi: 1'b1, sub: 1'b0};
      2:       op = '{a: A_SX, b: B_SX,     tgt: ACC_DEN,  hi: 1'b0, sub: 1'b1};
      3:       op = '{a: A_N,  b: B_SXY_LO, tgt: ACC_NUM,  hi: 1'b0, sub: 1'b0};
      4:       op = '{a: A_N,  b: B_SXY_HI, tgt: ACC_NUM,  hi: 1'b1, sub: 1'b0};
      5:       op = '{a: A_SX, b: B_SY,     tgt: ACC_NUM,  hi: 1'b0, sub: 1'b1};
      6:       op = '{a: A_SY, b: B_SXX_LO, tgt: ACC_PNUM, hi: 1'b0, sub: 1'b0};
      7:       op = '{a: A_SY, b: B_SXX_HI, tgt: ACC_PNUM, hi: 1'b1, sub: 1'b0};
      8:       op = '{a: A_SX, b: B_SXY_LO, tgt: ACC_PNUM, hi: 1'b0, sub: 1'b1};
      9:       op = '{a: A_SX, b: B_SXY_HI, tgt: ACC_PNUM, hi: 1'b1, sub: 1'b1};
      default: op = '{a: A_N,  b: B_SXX_LO, tgt: ACC_DEN,  hi: 1'b0, sub: 1'b0};
    endcase
    return op;
  endfunction

  state_t                    state;
  fit_status_t               status_q;
  logic [CNT_W-1:0]          count;
  logic signed [SUM_W-1:0]   sum_x;
  logic signed [SUM_W-1:0]   sum_y;
  logic signed [WIDE_W-1:0]  sum_xy;
  logic [WIDE_W-1:0]         sum_xx;
  logic                      overflowed;
  logic signed [SAMPLE_WIDTH-1:0] x_r;
  logic signed [SAMPLE_WIDTH-1:0] y_r;
  logic                      last_r;
  logic [OP_W-1:0]           step;
  logic signed [ACC_W-1:0]   acc_den;
  logic signed [ACC_W-1:0]   acc_num;
  logic signed [ACC_W-1:0]   acc_pnum;
  logic signed [RES_W-1:0]   slope_q;
  logic signed [RES_W-1:0]   icpt_q;
  logic                      sat_q;
  logic                      load_out;

  logic signed [MUL_W-1:0]   mul_a;
  logic signed [MUL_W-1:0]   mul_b;
  logic signed [MUL_W-1:0]   fit_a;
  logic signed [MUL_W-1:0]   fit_b;
  logic signed [PROD_W-1:0]  prod;
  fit_op_t                   issue_op;
  fit_op_t                   add_op;
  logic signed [ACC_W-1:0]   acc_base;
  logic signed [ACC_W-1:0]   term;
  logic signed [ACC_W-1:0]   acc_sum;

  logic [ACC_W-1:0]          num_mag;
  logic [ACC_W-1:0]          pnum_mag;
  logic [ACC_W-1:0]          den_mag;
  logic                      den_nz;
  logic                      div_start;
  logic                      div_neg;
  logic [NUM_W-1:0]          div_num;
  logic [DEN_W-1:0]          div_den;
  logic [RES_W-1:0]          div_quot;
  div_stat_t                 div_stat;

  assign in_ready = (state == S_IDLE);
  assign load_out = (state == S_OUT) && (!out_valid || out_ready);

  always_comb begin
    issue_op = fit_op(step);
    add_op   = fit_op(step - OP_W'(1));

    case (issue_op.a)
      A_SX:    fit_a = MUL_W'(sum_x);
      A_SY:    fit_a = MUL_W'(sum_y);
      default: fit_a = MUL_W'(count);
    endcase

    case (issue_op.b)
      B_SXX_HI: fit_b = MUL_W'(sum_xx[WIDE_W-1:HALF_W]);
      B_SXY_LO: fit_b = MUL_W'(sum_xy[HALF_W-1:0]);
      B_SXY_HI: fit_b = MUL_W'($signed(sum_xy[WIDE_W-1:HALF_W]));
      B_SX:     fit_b = MUL_W'(sum_x);
      B_SY:     fit_b = MUL_W'(sum_y);
      default:  fit_b = MUL_W'(sum_xx[HALF_W-1:0]);
    endcase

    case (state)
      S_MXY: begin
        mul_a = MUL_W'(x_r);
        mul_b = MUL_W'(y_r);
      end
      S_MXX: begin
        mul_a = MUL_W'(x_r);
        mul_b = MUL_W'(x_r);
      end
      default: begin
        mul_a = fit_a;
        mul_b = fit_b;
      end
    endcase

    case (add_op.tgt)
      ACC_NUM:  acc_base = acc_num;
      ACC_PNUM: acc_base = acc_pnum;
      default:  acc_base = acc_den;
    endcase
    term = ACC_W'(prod);
    if (add_op.hi) begin
      term = term << HALF_W;
    end
    acc_sum = add_op.sub ? (acc_base - term) : (acc_base + term);
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_comb begin
    num_mag  = acc_num[ACC_W-1] ? -acc_num : acc_num;
    pnum_mag = acc_pnum[ACC_W-1] ? -acc_pnum : acc_pnum;
    den_mag  = acc_den[ACC_W-1] ? -acc_den : acc_den;
    den_nz   = |acc_den;
    if (state == S_CHECK) begin
      div_num = NUM_W'(num_mag) << RESULT_FRAC;
      div_den = DEN_W'(den_mag);
      div_neg = acc_num[ACC_W-1] ^ acc_den[ACC_W-1];
    end else begin
      div_num = NUM_W'(pnum_mag) << RESULT_FRAC;
      div_den = DEN_W'(den_mag) << SAMPLE_FRAC;
      div_neg = acc_pnum[ACC_W-1] ^ acc_den[ACC_W-1];
    end
    div_start = ((state == S_CHECK) && !overflowed && den_nz) ||
                ((state == S_DIV_SLOPE) && div_stat.done);
  end

  lslf_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .neg   (div_neg),
    .num   (div_num),
    .den   (div_den),
    .quot  (div_quot),
    .stat  (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      sum_x      <= '0;
      sum_y      <= '0;
      sum_xy     <= '0;
      sum_xx     <= '0;
      overflowed <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            x_r    <= sample_x;
            y_r    <= sample_y;
            last_r <= last_sample;
            step   <= '0;
            if (count >= CNT_W'(MAX_SAMPLES)) begin
              overflowed <= 1'b1;
              state      <= last_sample ? S_PROD : S_IDLE;
            end else begin
              state <= S_MXY;
            end
          end
        end
        S_MXY: state <= S_MXX;
        S_MXX: begin
          sum_xy <= sum_xy + prod[WIDE_W-1:0];
          state  <= S_ACC;
        end
        S_ACC: begin
          sum_xx <= sum_xx + prod[WIDE_W-1:0];
          sum_x  <= sum_x + SUM_W'(x_r);
          sum_y  <= sum_y + SUM_W'(y_r);
          count  <= count + CNT_W'(1);
          step   <= '0;
          state  <= last_r ? S_PROD : S_IDLE;
        end
        S_PROD: begin
          step <= step + OP_W'(1);
          if (step == '0) begin
            acc_den  <= '0;
            acc_num  <= '0;
            acc_pnum <= '0;
          end else begin
            case (add_op.tgt)
              ACC_NUM:  acc_num  <= acc_sum;
              ACC_PNUM: acc_pnum <= acc_sum;
              default:  acc_den  <= acc_sum;
            endcase
          end
          if (step == OP_W'(FIT_OPS)) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          sat_q <= 1'b0;
          if (overflowed) begin
            status_q <= ST_TOO_MANY;
            slope_q  <= '0;
            icpt_q   <= '0;
            state    <= S_OUT;
          end else if (!den_nz) begin
            status_q <= ST_SINGULAR;
            slope_q  <= '0;
            icpt_q   <= '0;
            state    <= S_OUT;
          end else begin
            state <= S_DIV_SLOPE;
          end
        end
        S_DIV_SLOPE: begin
          if (div_stat.done) begin
            slope_q <= div_quot;
            sat_q   <= div_stat.sat;
            state   <= S_DIV_ICPT;
          end
        end
        S_DIV_ICPT: begin
          if (div_stat.done) begin
            icpt_q   <= div_quot;
            status_q <= (sat_q || div_stat.sat) ? ST_SATURATED : ST_OK;
            state    <= S_OUT;
          end
        end
        S_OUT: begin
          if (load_out) begin
            slope        <= slope_q;
            intercept    <= icpt_q;
            sample_count <= COUNT_OUT_W'(count);
            fit_status   <= status_q;
            count        <= '0;
            sum_x        <= '0;
            sum_y        <= '0;
            sum_xy       <= '0;
            sum_xx       <= '0;
            overflowed   <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `LSLF_ASSERT_SAME(a_count_bound, 1'b1, count <= CNT_W'(MAX_SAMPLES), "sample count above limit")
  `LSLF_ASSERT_SAME(a_div_start_idle, div_start, !div_stat.busy, "divider started while busy")
  `LSLF_ASSERT_NEXT(a_result_load, load_out, out_valid && (state == S_IDLE), "result not loaded")
  `LSLF_ASSERT_SAME(a_special_zero,
    out_valid && (fit_status == ST_SINGULAR || fit_status == ST_TOO_MANY),
    (slope == '0) && (intercept == '0), "nonzero fit on failed run")
  `LSLF_ASSERT_SAME(a_too_many_count, out_valid && (fit_status == ST_TOO_MANY),
    sample_count == COUNT_OUT_W'(MAX_SAMPLES), "count wrong on full run")

endmodule

FILE: hw/rtl/lslf_div.sv
// Restoring divider with round-to-nearest and 32-bit saturation
module lslf_div #(
  parameter int NUM_W = lslf_pkg::ACC_W + lslf_pkg::DEF_RESULT_FRAC,
  parameter int DEN_W = lslf_pkg::ACC_W + lslf_pkg::DEF_SAMPLE_FRAC
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        neg,
  input  logic [NUM_W-1:0]            num,
  input  logic [DEN_W-1:0]            den,
  output logic [lslf_pkg::RES_W-1:0]  quot,
  output lslf_pkg::div_stat_t         stat
);
  import lslf_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam logic [Q_W:0] LIM_POS = (Q_W + 1)'((64'd1 << (RES_W - 1)) - 64'd1);
  localparam logic [Q_W:0] LIM_NEG = (Q_W + 1)'(64'd1 << (RES_W - 1));
  localparam logic [RES_W-1:0] RES_MAX = {1'b0, {(RES_W - 1){1'b1}}};
  localparam logic [RES_W-1:0] RES_MIN = {1'b1, {(RES_W - 1){1'b0}}};

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_ROUND} dstate_t;

  dstate_t          dstate;
  logic [NUM_W-1:0] numsh;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] rem_next;
  logic [Q_W-1:0]   q;
  logic             qovf;
  logic             neg_r;
  logic [CNT_W-1:0] cnt;
  logic             sat;
  logic             done;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;
  logic             rnd;
  logic [Q_W:0]     q_rnd;
  logic [Q_W:0]     lim;
  logic             over;
  logic [RES_W-1:0] quot_next;

  always_comb begin
    trial     = {rem, numsh[NUM_W-1]};
    diff      = trial - {1'b0, den_r};
    ge        = trial >= {1'b0, den_r};
    rem_next  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    rnd       = {rem, 1'b0} >= {1'b0, den_r};
    q_rnd     = {1'b0, q} + (Q_W + 1)'(rnd);
    lim       = neg_r ? LIM_NEG : LIM_POS;
    over      = qovf || (q_rnd > lim);
    if (over) begin
      quot_next = neg_r ? RES_MIN : RES_MAX;
    end else if (neg_r) begin
      quot_next = -q_rnd[RES_W-1:0];
    end else begin
      quot_next = q_rnd[RES_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dstate <= D_IDLE;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      case (dstate)
        D_IDLE: begin
          if (start) begin
            numsh  <= num;
            den_r  <= den;
            neg_r  <= neg;
            rem    <= '0;
            q      <= '0;
            qovf   <= 1'b0;
            cnt    <= CNT_W'(NUM_W);
            dstate <= D_RUN;
          end
        end
        D_RUN: begin
          rem   <= rem_next;
          q     <= {q[Q_W-2:0], ge};
          qovf  <= qovf | q[Q_W-1];
          numsh <= numsh << 1;
          cnt   <= cnt - CNT_W'(1);
          if (cnt == CNT_W'(1)) begin
            dstate <= D_ROUND;
          end
        end
        D_ROUND: begin
          quot   <= quot_next;
          sat    <= over;
          done   <= 1'b1;
          dstate <= D_IDLE;
        end
        default: dstate <= D_IDLE;
      endcase
    end
  end

  assign stat.busy = (dstate != D_IDLE);
  assign stat.done = done;
  assign stat.sat  = sat;

endmodule
